### rtl/flh_pkg.sv
// ----------------------------------------------------------------------------
// flh_pkg
// Shared constants and types for the first-fit free-list heap allocator.
// ----------------------------------------------------------------------------
package flh_pkg;

  localparam int HEAP_UNITS   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int ADDR_W       = $clog2(HEAP_UNITS);
  localparam int SIZE_W       = 13;
  localparam int BYTES_W      = 16;
  localparam int HB_SHIFT     = $clog2(HEADER_BYTES);
  localparam int STEP_W       = $clog2(HEAP_UNITS + 1);
  localparam int SUM_W        = SIZE_W + 1;
  localparam int UBYTES_W     = BYTES_W + 1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOM  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;

  // Header memory access: one shared read address, one write port per array
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  next_we;
    addr_t next_waddr;
    addr_t next_wdata;
    logic  size_we;
    addr_t size_waddr;
    size_t size_wdata;
  } mem_req_t;

  typedef struct packed {
    addr_t next;
    size_t size;
  } mem_rsp_t;

endpackage

### rtl/free_list_heap_allocator.sv
// Throughput: one request at a time; the list walk through the single read port of
//   the header memory (one node per cycle) sets the rate.
// Reset: synchronous; S_INIT0 and S_INIT1 write the sentinel and initial block
//   headers, then in_ready rises. Header memory contents are not cleared otherwise.
// ----------------------------------------------------------------------------
// free_list_heap_allocator
// First-fit, address-ordered circular free list with roving start and
// coalescing on free, over a fixed pool of header units.
// ----------------------------------------------------------------------------
module free_list_heap_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [flh_pkg::BYTES_W-1:0] in_request_bytes,
  input  logic [flh_pkg::ADDR_W-1:0]  in_block_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [flh_pkg::ADDR_W-1:0]  out_granted_address,
  output logic                        out_status
);
  import flh_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  logic     res_valid, res_ready, res_status;
  addr_t    res_addr;

  logic     out_valid_r, out_valid_nxt;
  addr_t    out_addr_r;
  logic     out_status_r;

  flh_hdr_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  flh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (in_req_type),
    .request_bytes (in_request_bytes),
    .block_address (in_block_address),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_addr      (res_addr),
    .res_status    (res_status),
    .mem_req       (mem_req),
    .mem_rsp       (mem_rsp)
  );

  // output register: loads when empty or being drained by a transfer
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_addr_r   <= res_addr;
      out_status_r <= res_status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

endmodule

### rtl/flh_hdr_mem.sv
// ----------------------------------------------------------------------------
// flh_hdr_mem
// Block header storage: next pointer and size arrays, registered read.
// ----------------------------------------------------------------------------
module flh_hdr_mem (
  input  logic              clk,
  input  flh_pkg::mem_req_t req,
  output flh_pkg::mem_rsp_t rsp
);
  import flh_pkg::*;

  addr_t next_mem [HEAP_UNITS];
  size_t size_mem [HEAP_UNITS];
  addr_t rd_next_r;
  size_t rd_size_r;

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_waddr] <= req.next_wdata;
    end
    if (req.rd_en) begin
      rd_next_r <= next_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.size_we) begin
      size_mem[req.size_waddr] <= req.size_wdata;
    end
    if (req.rd_en) begin
      rd_size_r <= size_mem[req.rd_addr];
    end
  end

  assign rsp.next = rd_next_r;
  assign rsp.size = rd_size_r;

endmodule

### rtl/flh_ctrl.sv
// ----------------------------------------------------------------------------
// flh_ctrl
// Request sequencer: walks the free list through the header memory,
// carves or unlinks on allocate, inserts and coalesces on free.
// ----------------------------------------------------------------------------
module flh_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [flh_pkg::BYTES_W-1:0] request_bytes,
  input  flh_pkg::addr_t             block_address,
  output logic                       res_valid,
  input  logic                       res_ready,
  output flh_pkg::addr_t             res_addr,
  output logic                       res_status,
  output flh_pkg::mem_req_t          mem_req,
  input  flh_pkg::mem_rsp_t          mem_rsp
);
  import flh_pkg::*;

  typedef enum logic [11:0] {
    S_INIT0   = 12'b0000_0000_0001,
    S_INIT1   = 12'b0000_0000_0010,
    S_IDLE    = 12'b0000_0000_0100,
    S_A_HEAD  = 12'b0000_0000_1000,
    S_A_CHK   = 12'b0000_0001_0000,
    S_A_CARVE = 12'b0000_0010_0000,
    S_F_SRCH  = 12'b0000_0100_0000,
    S_F_RBP   = 12'b0000_1000_0000,
    S_F_RNX   = 12'b0001_0000_0000,
    S_F_RP    = 12'b0010_0000_0000,
    S_F_W2    = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  addr_t  rover_r, rover_nxt;
  addr_t  p_r, p_nxt;
  addr_t  prev_r, prev_nxt;
  addr_t  bp_r, bp_nxt;
  addr_t  nx_r, nx_nxt;
  addr_t  nnx_r, nnx_nxt;
  size_t  units_r, units_nxt;
  size_t  sbp_r, sbp_nxt;
  size_t  snx_r, snx_nxt;
  size_t  sp_r, sp_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  addr_t  res_addr_r, res_addr_nxt;
  logic   res_status_r, res_status_nxt;

  logic   fit, exact, steps_out, brk, merge1, merge2;
  size_t  remain, new_sbp;
  addr_t  carve_q, new_nbp, bp_in;
  size_t  units_in;

  assign units_in = SIZE_W'((UBYTES_W'(request_bytes) + UBYTES_W'(HEADER_BYTES - 1))
                            >> HB_SHIFT) + SIZE_W'(1);
  assign bp_in    = block_address - addr_t'(1);

  assign fit       = (mem_rsp.size >= units_r);
  assign exact     = (mem_rsp.size == units_r);
  assign remain    = mem_rsp.size - units_r;
  assign carve_q   = p_r + remain[ADDR_W-1:0];
  assign steps_out = (steps_r == STEP_W'(HEAP_UNITS));

  // insertion point: bp strictly between p and its successor, or past the wrap
  assign brk = ((bp_r > p_r) && (bp_r < mem_rsp.next)) ||
               ((p_r >= mem_rsp.next) && ((bp_r > p_r) || (bp_r < mem_rsp.next)));

  assign merge1  = (SUM_W'(bp_r) + SUM_W'(sbp_r)) == SUM_W'(nx_r);
  assign new_sbp = merge1 ? (sbp_r + snx_r) : sbp_r;
  assign new_nbp = merge1 ? nnx_r : nx_r;
  assign merge2  = (SUM_W'(p_r) + SUM_W'(sp_r)) == SUM_W'(bp_r);

  always_comb begin
    state_nxt      = state_r;
    rover_nxt      = rover_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    bp_nxt         = bp_r;
    nx_nxt         = nx_r;
    nnx_nxt        = nnx_r;
    units_nxt      = units_r;
    sbp_nxt        = sbp_r;
    snx_nxt        = snx_r;
    sp_nxt         = sp_r;
    steps_nxt      = steps_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    mem_req        = '0;

    unique case (state_r)
      S_INIT0: begin
        // sentinel: size zero, points at the initial block
        mem_req.next_we    = 1'b1;
        mem_req.next_waddr = addr_t'(0);
        mem_req.next_wdata = addr_t'(1);
        mem_req.size_we    = 1'b1;
        mem_req.size_waddr = addr_t'(0);
        mem_req.size_wdata = size_t'(0);
        state_nxt          = S_INIT1;
      end
      S_INIT1: begin
        mem_req.next_we    = 1'b1;
        mem_req.next_waddr = addr_t'(1);
        mem_req.next_wdata = addr_t'(0);
        mem_req.size_we    = 1'b1;
        mem_req.size_waddr = addr_t'(1);
        mem_req.size_wdata = size_t'(HEAP_UNITS - 1);
        state_nxt          = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          steps_nxt       = '0;
          p_nxt           = rover_r;
          prev_nxt        = rover_r;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rover_r;
          if (req_type == REQ_FREE) begin
            bp_nxt    = bp_in;
            state_nxt = S_F_SRCH;
          end else begin
            units_nxt = units_in;
            state_nxt = S_A_HEAD;
          end
        end
      end
      S_A_HEAD: begin
        p_nxt           = mem_rsp.next;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = mem_rsp.next;
        state_nxt       = S_A_CHK;
      end
      S_A_CHK: begin
        if (fit) begin
          rover_nxt      = prev_r;
          res_status_nxt = STATUS_DONE;
          if (exact) begin
            mem_req.next_we    = 1'b1;
            mem_req.next_waddr = prev_r;
            mem_req.next_wdata = mem_rsp.next;
            res_addr_nxt       = p_r + addr_t'(1);
            state_nxt          = S_DONE;
          end else begin
            // shrink the block, grant its tail
            mem_req.size_we    = 1'b1;
            mem_req.size_waddr = p_r;
            mem_req.size_wdata = remain;
            p_nxt              = carve_q;
            state_nxt          = S_A_CARVE;
          end
        end else if ((p_r == rover_r) || steps_out) begin
          res_addr_nxt   = '0;
          res_status_nxt = STATUS_OOM;
          state_nxt      = S_DONE;
        end else begin
          steps_nxt       = steps_r + STEP_W'(1);
          prev_nxt        = p_r;
          p_nxt           = mem_rsp.next;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mem_rsp.next;
        end
      end
      S_A_CARVE: begin
        mem_req.size_we    = 1'b1;
        mem_req.size_waddr = p_r;
        mem_req.size_wdata = units_r;
        res_addr_nxt       = p_r + addr_t'(1);
        state_nxt          = S_DONE;
      end
      S_F_SRCH: begin
        if (brk) begin
          nx_nxt          = mem_rsp.next;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = bp_r;
          state_nxt       = S_F_RBP;
        end else if (steps_out) begin
          // list does not close: drop the free
          res_addr_nxt   = '0;
          res_status_nxt = STATUS_DONE;
          state_nxt      = S_DONE;
        end else begin
          steps_nxt       = steps_r + STEP_W'(1);
          p_nxt           = mem_rsp.next;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mem_rsp.next;
        end
      end
      S_F_RBP: begin
        sbp_nxt         = mem_rsp.size;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = nx_r;
        state_nxt       = S_F_RNX;
      end
      S_F_RNX: begin
        snx_nxt         = mem_rsp.size;
        nnx_nxt         = mem_rsp.next;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = p_r;
        state_nxt       = S_F_RP;
      end
      S_F_RP: begin
        // coalesce with the upper neighbor
        sp_nxt             = mem_rsp.size;
        mem_req.next_we    = 1'b1;
        mem_req.next_waddr = bp_r;
        mem_req.next_wdata = new_nbp;
        mem_req.size_we    = merge1;
        mem_req.size_waddr = bp_r;
        mem_req.size_wdata = new_sbp;
        sbp_nxt            = new_sbp;
        nnx_nxt            = new_nbp;
        state_nxt          = S_F_W2;
      end
      S_F_W2: begin
        // coalesce with the lower neighbor
        mem_req.next_we    = 1'b1;
        mem_req.next_waddr = p_r;
        mem_req.next_wdata = merge2 ? nnx_r : bp_r;
        mem_req.size_we    = merge2;
        mem_req.size_waddr = p_r;
        mem_req.size_wdata = sp_r + sbp_r;
        rover_nxt          = p_r;
        res_addr_nxt       = '0;
        res_status_nxt     = STATUS_DONE;
        state_nxt          = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT0;
      rover_r <= '0;
    end else begin
      state_r <= state_nxt;
      rover_r <= rover_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    prev_r       <= prev_nxt;
    bp_r         <= bp_nxt;
    nx_r         <= nx_nxt;
    nnx_r        <= nnx_nxt;
    units_r      <= units_nxt;
    sbp_r        <= sbp_nxt;
    snx_r        <= snx_nxt;
    sp_r         <= sp_nxt;
    steps_r      <= steps_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res_addr   = res_addr_r;
  assign res_status = res_status_r;

endmodule

### dv/flh_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flh_checker
// Watches both channels of the heap allocator. It keeps its own copy of the
// block headers and the rover, works out the reply for each accepted request
// and compares it field by field with the reply that comes out.
// ----------------------------------------------------------------------------
module flh_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [flh_pkg::BYTES_W-1:0] in_request_bytes,
  input  flh_pkg::addr_t              in_block_address,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  flh_pkg::addr_t              out_granted_address,
  input  logic                        out_status,
  output int                          mismatches
);
  import flh_pkg::*;

  localparam int UNIT_MASK = HEAP_UNITS - 1;

  typedef struct packed {
    addr_t grant;
    logic  status;
  } reply_t;

  addr_t  next_tbl [HEAP_UNITS];
  size_t  size_tbl [HEAP_UNITS];
  int     rover;
  reply_t reply_q[$];
  reply_t due_reply;

  // First fit from the list node after the rover; a larger block gives up its tail.
  function automatic reply_t carve_alloc(input logic [BYTES_W-1:0] nbytes);
    int     units;
    int     prev;
    int     cur;
    int     steps;
    reply_t r;
    units    = (int'(nbytes) + HEADER_BYTES - 1) / HEADER_BYTES + 1;
    prev     = rover;
    cur      = int'(next_tbl[prev]);
    steps    = 0;
    r.grant  = '0;
    r.status = STATUS_OOM;
    while (1'b1) begin
      if (int'(size_tbl[cur]) >= units) begin
        if (int'(size_tbl[cur]) == units) begin
          next_tbl[prev] = next_tbl[cur];
        end else begin
          size_tbl[cur] = size_t'(int'(size_tbl[cur]) - units);
          cur = (cur + int'(size_tbl[cur])) & UNIT_MASK;
          size_tbl[cur] = size_t'(units);
        end
        rover    = prev;
        r.grant  = addr_t'((cur + 1) & UNIT_MASK);
        r.status = STATUS_DONE;
        return r;
      end
      if (cur == rover) return r;
      steps++;
      // a damaged list may loop without passing the rover
      if (steps > HEAP_UNITS) return r;
      prev = cur;
      cur  = int'(next_tbl[cur]);
    end
    return r;
  endfunction

  // Address-ordered insert, merging with the free neighbors on both sides.
  function automatic void coalesce_free(input addr_t uaddr);
    int bp;
    int p;
    int nx;
    int steps;
    bp    = (int'(uaddr) + HEAP_UNITS - 1) & UNIT_MASK;
    p     = rover;
    steps = 0;
    while (1'b1) begin
      nx = int'(next_tbl[p]);
      if (bp > p && bp < nx) break;
      if (p >= nx && (bp > p || bp < nx)) break;
      steps++;
      if (steps > HEAP_UNITS) return;
      p = nx;
    end
    nx = int'(next_tbl[p]);
    // neighbor checks compare without wrapping
    if (bp + int'(size_tbl[bp]) == nx) begin
      size_tbl[bp] = size_t'(int'(size_tbl[bp]) + int'(size_tbl[nx]));
      next_tbl[bp] = next_tbl[nx];
    end else begin
      next_tbl[bp] = addr_t'(nx);
    end
    if (p + int'(size_tbl[p]) == bp) begin
      size_tbl[p] = size_t'(int'(size_tbl[p]) + int'(size_tbl[bp]));
      next_tbl[p] = next_tbl[bp];
    end else begin
      next_tbl[p] = addr_t'(bp);
    end
    rover = p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HEAP_UNITS; i++) begin
        next_tbl[i] = '0;
        size_tbl[i] = '0;
      end
      next_tbl[0] = addr_t'(1);
      size_tbl[1] = size_t'(HEAP_UNITS - 1);
      rover       = 0;
      reply_q.delete();
      mismatches  = 0;
    end else begin
      // a reply never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("reply transfer with nothing outstanding: granted_address %0d status %0d",
                 out_granted_address, out_status);
          mismatches++;
        end else begin
          due_reply = reply_q.pop_front();
          if (out_granted_address !== due_reply.grant) begin
            $error("granted_address: expected %0d, got %0d", due_reply.grant,
                   out_granted_address);
            mismatches++;
          end
          if (out_status !== due_reply.status) begin
            $error("status: expected %0d, got %0d", due_reply.status, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_FREE) begin
          coalesce_free(in_block_address);
          due_reply.grant  = '0;
          due_reply.status = STATUS_DONE;
          reply_q.push_back(due_reply);
        end else begin
          reply_q.push_back(carve_alloc(in_request_bytes));
        end
      end
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the heap allocator: a directed
// opening, a long run of well-formed traffic over the blocks it holds, and a
// closing stretch that mixes allocations with double and stray frees. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import flh_pkg::*;

  localparam int IDLE_MAX          = 13;
  localparam int WELL_FORMED_ITEMS = 1410;
  localparam int STRAY_ITEMS       = 120;
  localparam int STALL_LIMIT       = 20000;
  localparam int TAIL_CYCLES       = 16;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_req_type;
  logic [BYTES_W-1:0] in_request_bytes;
  addr_t              in_block_address;
  logic               out_valid;
  logic               out_ready;
  addr_t              out_granted_address;
  logic               out_status;
  int                 mismatches;

  logic  kind_q[$];
  addr_t live_blocks[$];
  addr_t once_granted[$];
  logic  granted_seen [HEAP_UNITS];
  int    n_sent;
  int    n_granted;
  int    n_oom;
  int    n_freed;
  int    quiet_cycles;
  bit    src_idle;
  bit    sink_idle;

  free_list_heap_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_request_bytes    (in_request_bytes),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

  flh_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_request_bytes    (in_request_bytes),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .mismatches          (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Tracks outstanding requests, the blocks held, and the stall watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (kind_q.size() != 0) begin
          if (kind_q.pop_front() == REQ_FREE) begin
            n_freed++;
          end else if (out_status == STATUS_DONE) begin
            n_granted++;
            live_blocks.push_back(out_granted_address);
            if (!granted_seen[out_granted_address]) begin
              granted_seen[out_granted_address] = 1'b1;
              once_granted.push_back(out_granted_address);
            end
          end else begin
            n_oom++;
          end
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        kind_q.push_back(in_req_type);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No transfer for %0d cycles, giving up.", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [BYTES_W-1:0] pick_bytes();
    int r;
    r = $urandom_range(99, 0);
    if (r < 65) return BYTES_W'($urandom_range(256, 0));
    if (r < 90) return BYTES_W'($urandom_range(2048, 0));
    if (r < 98) return BYTES_W'($urandom_range(16384, 0));
    return BYTES_W'($urandom_range(65535, 0));
  endfunction

  function automatic addr_t take_live();
    int    k;
    addr_t a;
    k = $urandom_range(live_blocks.size() - 1, 0);
    a = live_blocks[k];
    live_blocks.delete(k);
    return a;
  endfunction

  task automatic send_request(input logic kind, input logic [BYTES_W-1:0] nbytes,
                              input addr_t addr);
    int gap;
    gap = src_idle ? $urandom_range(IDLE_MAX, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = kind;
    in_request_bytes = nbytes;
    in_block_address = addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // the field a request ignores still carries random bits
  task automatic send_alloc(input logic [BYTES_W-1:0] nbytes);
    send_request(REQ_ALLOC, nbytes, addr_t'($urandom));
  endtask

  task automatic send_free(input addr_t addr);
    send_request(REQ_FREE, BYTES_W'($urandom), addr);
  endtask

  // Result side: random stall before each transfer, with stretches of none.
  initial begin : sink_proc
    int stall;
    int served;
    out_ready = 1'b0;
    sink_idle = 1'b1;
    served    = 0;
    @(posedge rst_n);
    forever begin
      if (served % 80 == 0) sink_idle = ($urandom_range(3, 0) != 0);
      stall = sink_idle ? $urandom_range(IDLE_MAX, 0) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      served++;
      @(negedge clk);
    end
  end

  initial begin : stim_proc
    int sel;
    in_valid         = 1'b0;
    in_req_type      = REQ_ALLOC;
    in_request_bytes = '0;
    in_block_address = '0;
    rst_n            = 1'b0;
    src_idle         = 1'b1;
    n_sent           = 0;
    n_granted        = 0;
    n_oom            = 0;
    n_freed          = 0;
    for (int i = 0; i < HEAP_UNITS; i++) granted_seen[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero bytes takes one unit off the top, so the grant wraps to address 0
    send_alloc(16'd0);
    send_free(addr_t'(0));
    send_alloc(16'hFFFF);                 // more than the pool
    send_alloc(16'd65504);                // exact fit of the whole pool
    send_alloc(16'd1);                    // list holds only the sentinel
    send_free(addr_t'(2));
    // five two-unit blocks carved from the top down
    repeat (5) send_alloc(16'd16);
    send_free(addr_t'(4093));             // neighbors both in use
    send_free(addr_t'(4089));
    send_free(addr_t'(4091));             // joins free blocks on both sides
    send_free(addr_t'(4095));             // joins the block below only
    send_free(addr_t'(4087));
    send_alloc(16'd32768);
    send_free(addr_t'(2048));
    // header is the sentinel: the search never finds a slot and runs out of steps
    send_free(addr_t'(1));

    @(negedge clk);
    in_valid = 1'b0;
    while (kind_q.size() != 0) @(negedge clk);
    live_blocks.delete();

    for (int i = 0; i < WELL_FORMED_ITEMS; i++) begin
      if (i % 100 == 0) src_idle = ($urandom_range(3, 0) != 0);
      if (live_blocks.size() == 0 ||
          $urandom_range(99, 0) < (live_blocks.size() < 48 ? 60 : 40)) begin
        send_alloc(pick_bytes());
      end else begin
        send_free(take_live());
      end
    end

    // double and stale frees damage the list; every header read was written once
    for (int i = 0; i < STRAY_ITEMS; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 45) begin
        send_alloc(pick_bytes());
      end else if (sel < 80) begin
        send_free(once_granted[$urandom_range(once_granted.size() - 1, 0)]);
      end else if (sel < 95 && live_blocks.size() != 0) begin
        send_free(take_live());
      end else begin
        send_free(addr_t'($urandom_range(2, 1)));
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (kind_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d grants, %0d out-of-memory replies, %0d frees.",
             n_sent, n_granted, n_oom, n_freed);
    $display("Traffic ended with double, stale and sentinel frees on a damaged list.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
